/* design/wfpd_pkg.sv */
// Package for the wall-following PID drive core.
// Holds the beat structs, register indexes and fixed controller constants.
// No dependencies.
package wfpd_pkg;

  typedef struct packed {
    logic [7:0] front_left;
    logic [7:0] back_left;
    logic [7:0] back_right;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
  } out_beat_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DIST = 2'd1;

  localparam logic signed [7:0] BASE_SPEED_RST  = 8'sd60;
  localparam logic [5:0]        TARGET_DIST_RST = 6'd15;

  localparam logic [7:0] FRONT_FAR  = 8'd50;
  localparam logic [7:0] BACK_FAR   = 8'd35;
  localparam logic [7:0] NEAR_RIGHT = 8'd5;

  // Width of the steering accumulator and of the Q10 drive sums.
  localparam int unsigned ACC_W = 28;

  localparam logic signed [ACC_W-1:0] GAIN_P_Q10 = 28'sd2355;
  localparam logic signed [ACC_W-1:0] GAIN_D_Q10 = 28'sd40960;
  localparam logic signed [ACC_W-1:0] GAIN_I_Q10 = 28'sd61;

  localparam logic signed [9:0] BOTH_FAR_ERROR = 10'sd5;
  localparam logic signed [9:0] INTEGRAL_LIMIT = 10'sd100;

endpackage

/* design/wall_follow_pid_drive_core.sv */
// Top level of the wall-following PID drive core: handshakes, state, config.
// Depends on wfpd_pkg and wfpd_steer.
//
//   Channel | Ports                              | Direction | Beat
//   input   | in_valid, in_ready, in_data        | in        | wfpd_pkg::in_beat_t
//   result  | out_valid, out_ready, out_data     | out       | wfpd_pkg::out_beat_t
//   config  | cfg_we, cfg_index, cfg_wdata       | in        | write only, no wait
//
// One beat is accepted every cycle while results are not stalled. A result passes
// through the input register and then the result register around the steering
// datapath. Reset is synchronous: the config registers go to their defaults and the
// valid flags, previous readings and integral to zero. A stalled result holds both
// registers; the input side still takes a beat while the input register is empty.
module wall_follow_pid_drive_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wfpd_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wfpd_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [wfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wfpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic signed [7:0]   speed_r;
  logic [5:0]          target_r;
  logic [7:0]          last_front_r;
  logic [7:0]          last_back_r;
  logic signed [7:0]   integral_r;
  logic                in_valid_r;
  wfpd_pkg::in_beat_t  in_beat_r;
  logic                out_valid_r;
  wfpd_pkg::out_beat_t out_beat_r;
  wfpd_pkg::out_beat_t drive;
  logic signed [7:0]   integral_nxt;
  logic                advance;

  wfpd_steer u_steer (
    .beat            (in_beat_r),
    .base_speed      (speed_r),
    .target_distance (target_r),
    .last_front      (last_front_r),
    .last_back       (last_back_r),
    .integral_sum    (integral_r),
    .drive           (drive),
    .integral_nxt    (integral_nxt)
  );

  // The held beat moves to the result register whenever that register is free.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= wfpd_pkg::BASE_SPEED_RST;
      target_r <= wfpd_pkg::TARGET_DIST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wfpd_pkg::CFG_BASE_SPEED:  speed_r <= cfg_wdata;
        wfpd_pkg::CFG_TARGET_DIST: target_r <= cfg_wdata[5:0];
        default: begin
          speed_r <= speed_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      last_front_r <= '0;
      last_back_r  <= '0;
      integral_r   <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        last_front_r <= in_beat_r.front_left;
        last_back_r  <= in_beat_r.back_left;
        integral_r   <= integral_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_beat_r <= in_data;
    end
    if (advance) begin
      out_beat_r <= drive;
    end
  end

endmodule

/* design/wfpd_steer.sv */
// Combinational steering datapath for the wall-following PID drive core.
// Computes both motor drives and the next integral from one beat and state.
// Depends on wfpd_pkg.
module wfpd_steer (
  input  wfpd_pkg::in_beat_t  beat,
  input  logic signed [7:0]   base_speed,
  input  logic [5:0]          target_distance,
  input  logic [7:0]          last_front,
  input  logic [7:0]          last_back,
  input  logic signed [7:0]   integral_sum,
  output wfpd_pkg::out_beat_t drive,
  output logic signed [7:0]   integral_nxt
);

  localparam int unsigned AW = wfpd_pkg::ACC_W;
  localparam int unsigned DW = AW - 10;

  logic              front_far;
  logic              back_far;
  logic [8:0]        sum_fb;
  logic [8:0]        sum_prev;
  logic [5:0]        target_back;
  logic signed [9:0] f_s;
  logic signed [9:0] b_s;
  logic signed [9:0] avg_s;
  logic signed [9:0] pf_s;
  logic signed [9:0] pb_s;
  logic signed [9:0] pavg_s;
  logic signed [9:0] p_err;
  logic signed [9:0] d_err;
  logic signed [9:0] integ;
  logic signed [AW-1:0] steer;
  logic signed [AW-1:0] base_q;
  logic signed [AW-1:0] left_q;
  logic signed [AW-1:0] right_q;
  logic signed [AW-1:0] left_adj;
  logic signed [AW-1:0] right_adj;
  logic signed [DW-1:0] left_raw;
  logic signed [DW-1:0] right_raw;
  logic signed [9:0]    spd_lo;
  logic signed [9:0]    spd_hi;
  logic signed [7:0]    spd_lo_sat;
  logic signed [7:0]    spd_hi_sat;

  always_comb begin
    front_far   = beat.front_left > wfpd_pkg::FRONT_FAR;
    back_far    = beat.back_left > wfpd_pkg::BACK_FAR;
    sum_fb      = {1'b0, beat.front_left} + {1'b0, beat.back_left};
    sum_prev    = {1'b0, last_front} + {1'b0, last_back};
    target_back = target_distance - {2'b00, target_distance[5:2]};
    f_s         = $signed({2'b00, beat.front_left});
    b_s         = $signed({2'b00, beat.back_left});
    avg_s       = $signed({2'b00, sum_fb[8:1]});
    pf_s        = $signed({2'b00, last_front});
    pb_s        = $signed({2'b00, last_back});
    pavg_s      = $signed({2'b00, sum_prev[8:1]});

    if (front_far && back_far) begin
      p_err = wfpd_pkg::BOTH_FAR_ERROR;
      d_err = '0;
    end else if (back_far) begin
      p_err = f_s - $signed({4'b0000, target_distance});
      d_err = f_s - pf_s;
    end else if (front_far) begin
      p_err = b_s - $signed({4'b0000, target_back});
      d_err = b_s - pb_s;
    end else begin
      p_err = avg_s - $signed({4'b0000, target_distance});
      d_err = avg_s - pavg_s;
    end

    integ = {{2{integral_sum[7]}}, integral_sum} + p_err;

    steer = AW'(p_err) * wfpd_pkg::GAIN_P_Q10
          + AW'(d_err) * wfpd_pkg::GAIN_D_Q10
          + AW'(integ) * wfpd_pkg::GAIN_I_Q10;

    base_q  = {{(AW-18){base_speed[7]}}, base_speed, 10'b0};
    left_q  = base_q - steer;
    right_q = base_q + steer;

    // Division by 1024 truncating toward zero: bias negatives before the shift.
    left_adj  = left_q + (left_q[AW-1] ? AW'(1023) : AW'(0));
    right_adj = right_q + (right_q[AW-1] ? AW'(1023) : AW'(0));
    left_raw  = left_adj[AW-1:10];
    right_raw = right_adj[AW-1:10];

    spd_lo = {{2{base_speed[7]}}, base_speed} - 10'sd2;
    spd_hi = {{2{base_speed[7]}}, base_speed} + 10'sd2;
    if (spd_lo < -10'sd127) begin
      spd_lo_sat = -8'sd127;
    end else if (spd_lo > 10'sd127) begin
      spd_lo_sat = 8'sd127;
    end else begin
      spd_lo_sat = spd_lo[7:0];
    end
    if (spd_hi < -10'sd127) begin
      spd_hi_sat = -8'sd127;
    end else if (spd_hi > 10'sd127) begin
      spd_hi_sat = 8'sd127;
    end else begin
      spd_hi_sat = spd_hi[7:0];
    end

    if (left_raw < -DW'(127) || right_raw > DW'(127)) begin
      drive.left_drive  = -8'sd127;
      drive.right_drive = 8'sd127;
    end else if (left_raw > DW'(127) || right_raw < -DW'(127)) begin
      drive.left_drive  = 8'sd127;
      drive.right_drive = -8'sd127;
    end else if (beat.back_right < wfpd_pkg::NEAR_RIGHT) begin
      drive.left_drive  = spd_lo_sat;
      drive.right_drive = spd_hi_sat;
    end else begin
      drive.left_drive  = left_raw[7:0];
      drive.right_drive = right_raw[7:0];
    end

    if (integ < wfpd_pkg::INTEGRAL_LIMIT && integ > -wfpd_pkg::INTEGRAL_LIMIT) begin
      integral_nxt = integ[7:0];
    end else begin
      integral_nxt = '0;
    end
  end

endmodule

/* verif/tb_wall_follow_pid_drive_core.sv */
// Self-checking testbench for wall_follow_pid_drive_core: PID steering, reading filter, limits.
// Depends on wfpd_pkg and the core RTL; predicts every drive beat and compares it in order.
module tb_wall_follow_pid_drive_core;

  localparam int FRONT_LIMIT  = 50;
  localparam int SIDE_LIMIT   = 35;
  localparam int RIGHT_NEAR   = 5;
  localparam int ERR_BOTH_FAR = 5;
  localparam int K_PROP       = 2355;
  localparam int K_RATE       = 40960;
  localparam int K_INTEG      = 61;
  localparam int Q10_ONE      = 1024;
  localparam int DRIVE_LIMIT  = 127;
  localparam int INTEG_BOUND  = 100;
  localparam logic [wfpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [wfpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int MAX_PRINTED  = 40;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  wfpd_pkg::in_beat_t              in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  wfpd_pkg::out_beat_t             out_data;
  logic                            cfg_we = 1'b0;
  logic [wfpd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wfpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: registers, previous readings and the integral term.
  logic signed [7:0] mdl_speed;
  logic [5:0]        mdl_target;
  logic [7:0]        prev_front;
  logic [7:0]        prev_back;
  logic signed [7:0] integral_acc;

  wfpd_pkg::out_beat_t expected_drives[$];
  wfpd_pkg::out_beat_t drive_want;
  int        error_count = 0;
  int        hold_request = 0;
  bit        idle_on = 1'b0;
  logic [7:0] wall_f = 8'd15;
  logic [7:0] wall_b = 8'd15;

  wall_follow_pid_drive_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTED)
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic int clamp_drive(input int v);
    if (v > DRIVE_LIMIT) return DRIVE_LIMIT;
    if (v < -DRIVE_LIMIT) return -DRIVE_LIMIT;
    return v;
  endfunction

  // Works out the drive beat for one accepted reading and advances the state.
  task automatic predict_drive(input logic [7:0] front, input logic [7:0] back,
                               input logic [7:0] right);
    int f, b, pf, pb, t, spd, err, rate, integ, steer, lft, rgt, lo, ro;
    bit ffar, bfar;
    wfpd_pkg::out_beat_t beat;
    f = int'(front);
    b = int'(back);
    pf = int'(prev_front);
    pb = int'(prev_back);
    t = int'(mdl_target);
    spd = int'(mdl_speed);
    ffar = f > FRONT_LIMIT;
    bfar = b > SIDE_LIMIT;
    if (ffar && bfar) begin
      err = ERR_BOTH_FAR;
      rate = 0;
    end else if (bfar) begin
      err = f - t;
      rate = f - pf;
    end else if (ffar) begin
      err = b - (t - t / 4);
      rate = b - pb;
    end else begin
      err = (f + b) / 2 - t;
      rate = (f + b) / 2 - (pf + pb) / 2;
    end
    integ = int'(integral_acc) + err;
    steer = err * K_PROP + rate * K_RATE + integ * K_INTEG;
    // Integer division truncates toward zero, as the drive path does.
    lft = (spd * Q10_ONE - steer) / Q10_ONE;
    rgt = (spd * Q10_ONE + steer) / Q10_ONE;
    if (lft < -DRIVE_LIMIT || rgt > DRIVE_LIMIT) begin
      lo = -DRIVE_LIMIT;
      ro = DRIVE_LIMIT;
    end else if (lft > DRIVE_LIMIT || rgt < -DRIVE_LIMIT) begin
      lo = DRIVE_LIMIT;
      ro = -DRIVE_LIMIT;
    end else if (int'(right) < RIGHT_NEAR) begin
      lo = clamp_drive(spd - 2);
      ro = clamp_drive(spd + 2);
    end else begin
      lo = lft;
      ro = rgt;
    end
    if (integ < INTEG_BOUND && integ > -INTEG_BOUND)
      integral_acc = integ[7:0];
    else
      integral_acc = '0;
    prev_front = front;
    prev_back = back;
    beat.left_drive = lo[7:0];
    beat.right_drive = ro[7:0];
    expected_drives.push_back(beat);
  endtask

  // Offers one reading and holds it until accepted; valid stays up for a following beat.
  task automatic send_reading(input logic [7:0] front, input logic [7:0] back,
                              input logic [7:0] right);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{front_left: front, back_left: back, back_right: right};
    do @(posedge clk); while (!in_ready);
    predict_drive(front, back, right);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers, then pokes one of the unused indexes, which must be ignored.
  task automatic program_regs(input logic [7:0] speed, input logic [7:0] target);
    cfg_we <= 1'b1;
    cfg_index <= wfpd_pkg::CFG_BASE_SPEED;
    cfg_wdata <= speed;
    @(posedge clk);
    mdl_speed = speed;
    cfg_index <= wfpd_pkg::CFG_TARGET_DIST;
    cfg_wdata <= target;
    @(posedge clk);
    mdl_target = target[5:0];
    cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] next_distance(input logic [7:0] cur, input int spread);
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 255);
      1: v = $urandom_range(0, spread);
      2, 3: v = int'(cur) - 1;
      4, 5: v = int'(cur) + 1;
      default: v = int'(cur);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic send_wander(input int n_items);
    logic [7:0] right;
    repeat (n_items) begin
      wall_f = next_distance(wall_f, 60);
      wall_b = next_distance(wall_b, 45);
      right = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      send_reading(wall_f, wall_b, right);
    end
  endtask

  // Drives the integral back to zero with a steady positive error, then a still
  // reading gives zero steering, so the near right wall sets the drives.
  task automatic near_wall_at(input logic [7:0] speed);
    program_regs(speed, 8'hC0);
    do send_reading(8'd50, 8'd35, 8'd7); while (integral_acc != 0);
    send_reading(8'd0, 8'd0, 8'd200);
    send_reading(8'd0, 8'd0, 8'd1);
    send_reading(8'd0, 8'd0, 8'd4);
    drain_results();
  endtask

  task automatic test_reading_filter();
    send_reading(8'd0, 8'd0, 8'd255);
    send_reading(8'd50, 8'd35, 8'd170);
    send_reading(8'd51, 8'd35, 8'd85);
    send_reading(8'd50, 8'd36, 8'd5);
    send_reading(8'd255, 8'd255, 8'd4);
    send_reading(8'd255, 8'd200, 8'd0);
    send_reading(8'd50, 8'd200, 8'd0);
    send_reading(8'd50, 8'd200, 8'd9);
    send_reading(8'd50, 8'd200, 8'd9);
    drain_results();
  endtask

  task automatic test_register_extremes();
    // Front far with the largest target gives a steep negative error.
    program_regs(8'h80, 8'hFF);
    send_reading(8'd255, 8'd0, 8'd3);
    send_reading(8'd255, 8'd0, 8'd3);
    send_reading(8'd255, 8'd0, 8'd3);
    drain_results();
    near_wall_at(8'h7F);
    near_wall_at(8'h80);
    near_wall_at(8'h83);
    near_wall_at(8'h7D);
  endtask

  task automatic test_output_backpressure();
    program_regs(8'd60, 8'd15);
    idle_on = 1'b0;
    hold_request = 60;
    send_wander(24);
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [7:0] speed;
    logic [7:0] target;
    for (int phase = 0; phase < 7; phase++) begin
      case ($urandom_range(0, 5))
        0: speed = 8'h80;
        1: speed = 8'h7F;
        2: speed = 8'h83;
        3: speed = 8'h7D;
        default: speed = 8'($urandom);
      endcase
      target = 8'($urandom);
      if ($urandom_range(0, 2) == 0)
        target[5:0] = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      program_regs(speed, target);
      // The final phase runs with no idling on either side.
      idle_on = (phase != 6);
      send_wander(240);
      drain_results();
    end
  endtask

  // Receiver: random stall bursts, plus a long hold-off when one is requested.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_drives.size() == 0) begin
        report_mismatch("drive beat with nothing pending", out_data.left_drive, 0);
      end else begin
        drive_want = expected_drives.pop_front();
        if (out_data.left_drive !== drive_want.left_drive)
          report_mismatch("left_drive", out_data.left_drive, drive_want.left_drive);
        if (out_data.right_drive !== drive_want.right_drive)
          report_mismatch("right_drive", out_data.right_drive, drive_want.right_drive);
      end
    end
  end

  initial begin
    mdl_speed = 8'sd60;
    mdl_target = 6'd15;
    prev_front = '0;
    prev_back = '0;
    integral_acc = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reading_filter();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    if (expected_drives.size() != 0)
      report_mismatch("drive beats never delivered", 0, expected_drives.size());
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
